// ----- hw/rtl/line_framed_message_fifo_assert.svh -----
// Assertion helpers, clocked on clk with rst_n as the disable.
`ifndef LINE_FRAMED_MESSAGE_FIFO_ASSERT_SVH
`define LINE_FRAMED_MESSAGE_FIFO_ASSERT_SVH

// Same-cycle implication.
`define LFMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LFMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lfmf_pkg.sv -----
package lfmf_pkg;

    localparam int SLOTS         = 8;
    localparam int MESSAGE_BYTES = 64;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int POS_W  = $clog2(MESSAGE_BYTES);
    localparam int DEPTH  = SLOTS * MESSAGE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef logic [CNT_W-1:0]  slot_cnt_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_GET   = 2'd1,
        REQ_FLUSH = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PUT  = 3'b010,
        S_GET  = 3'b100
    } state_t;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam pos_t POS_CLOSE = pos_t'(MESSAGE_BYTES - 3);
    localparam pos_t POS_LAST  = pos_t'(MESSAGE_BYTES - 1);

    localparam slot_cnt_t SLOT_WRAP = slot_cnt_t'(2 * SLOTS - 1);
    localparam slot_cnt_t SLOTS_CNT = slot_cnt_t'(SLOTS);

    // Slot counters run modulo 2*SLOTS so that full and empty differ.
    function automatic slot_cnt_t slot_inc(input slot_cnt_t c);
        slot_cnt_t r;
        if (c == SLOT_WRAP)
            r = '0;
        else
            r = c + slot_cnt_t'(1);
        return r;
    endfunction

    function automatic slot_cnt_t held_count(input slot_cnt_t ws, input slot_cnt_t rs);
        logic [CNT_W:0] d;
        d = {1'b0, ws} - {1'b0, rs};
        if (ws < rs)
            d = d + (CNT_W + 1)'(2 * SLOTS);
        return d[CNT_W-1:0];
    endfunction

    function automatic addr_t store_addr(input slot_cnt_t slot, input pos_t pos);
        slot_cnt_t idx;
        if (slot >= SLOTS_CNT)
            idx = slot - SLOTS_CNT;
        else
            idx = slot;
        return addr_t'(addr_t'(idx) * addr_t'(MESSAGE_BYTES) + addr_t'(pos));
    endfunction

    function automatic logic [3:0] count_out(input slot_cnt_t c);
        logic [CNT_W+3:0] w;
        w = (CNT_W + 4)'(c);
        return w[3:0];
    endfunction

endpackage

// ----- hw/rtl/lfmf_if.sv -----
interface lfmf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface lfmf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
    logic [3:0] message_count;

    modport source (output valid, output out_byte, output last, output status,
                    output message_count, input ready);
    modport sink   (input valid, input out_byte, input last, input status,
                    input message_count, output ready);
endinterface

// ----- hw/rtl/line_framed_message_fifo.sv -----
// channel | dir | payload                                      | handshake
// req     | in  | req_type[1:0], data_byte[7:0]                | valid/ready
// res     | out | out_byte[7:0], last, status[1:0], count[3:0] | valid/ready
//
// Put, flush and empty get each give one result. A put that closes a message then
// writes the trailing newline (newline put) or comma and newline (forced close)
// through the single store write port. Get: one byte per cycle unless res stalls.
// Reset clears counters and position; the message store is not cleared.
// A stalled result holds a get and new requests; a request is taken only in idle with the
// result register free or draining.
module line_framed_message_fifo (
    input  logic              clk,
    input  logic              rst_n,
    lfmf_req_if.sink          req,
    lfmf_res_if.source        res
);

    logic [7:0] message_store [lfmf_pkg::DEPTH];

    lfmf_pkg::state_t    state_reg, state_next;
    lfmf_pkg::slot_cnt_t ws_reg, ws_next;
    lfmf_pkg::slot_cnt_t rs_reg, rs_next;
    lfmf_pkg::pos_t      wpos_reg, wpos_next;
    lfmf_pkg::pos_t      j_reg, j_next;
    lfmf_pkg::addr_t     pend_addr_reg, pend_addr_next;
    logic [1:0]          pend_left_reg, pend_left_next;

    logic                ov_reg, ov_next;
    logic [7:0]          ob_reg, ob_next;
    logic                ol_reg, ol_next;
    logic [1:0]          os_reg, os_next;
    logic [3:0]          oc_reg, oc_next;

    logic [7:0]          rd_data_reg;
    lfmf_pkg::addr_t     rd_addr;
    logic                mem_we;
    lfmf_pkg::addr_t     mem_waddr;
    logic [7:0]          mem_wdata;

    lfmf_pkg::slot_cnt_t count_cur;
    lfmf_pkg::pos_t      put_pos;
    logic                out_free;
    logic                in_fire;
    logic                get_fin;
    logic                get_take;

    assign count_cur = lfmf_pkg::held_count(ws_reg, rs_reg);
    assign out_free  = !ov_reg || res.ready;
    assign req.ready = (state_reg == lfmf_pkg::S_IDLE) && out_free;
    assign in_fire   = req.valid && req.ready;
    assign put_pos   = (wpos_reg > lfmf_pkg::POS_CLOSE) ? lfmf_pkg::POS_CLOSE : wpos_reg;
    assign get_fin   = (rd_data_reg == lfmf_pkg::CH_NL) || (j_reg == lfmf_pkg::POS_LAST);
    assign get_take  = (state_reg == lfmf_pkg::S_GET) && out_free;

    assign res.valid         = ov_reg;
    assign res.out_byte      = ob_reg;
    assign res.last          = ol_reg;
    assign res.status        = os_reg;
    assign res.message_count = oc_reg;

    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        rs_next        = rs_reg;
        wpos_next      = wpos_reg;
        j_next         = j_reg;
        pend_addr_next = pend_addr_reg;
        pend_left_next = pend_left_reg;
        ov_next        = ov_reg && !res.ready;
        ob_next        = ob_reg;
        ol_next        = ol_reg;
        os_next        = os_reg;
        oc_next        = oc_reg;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = (pend_left_reg == 2'd2) ? lfmf_pkg::CH_COMMA : lfmf_pkg::CH_NL;

        case (state_reg)
            lfmf_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    ov_next = 1'b1;
                    ob_next = 8'd0;
                    ol_next = 1'b1;
                    os_next = lfmf_pkg::ST_OK;
                    oc_next = lfmf_pkg::count_out(count_cur);
                    case (req.req_type)
                        lfmf_pkg::REQ_PUT:
                        begin
                            if (count_cur >= lfmf_pkg::SLOTS_CNT)
                            begin
                                os_next = lfmf_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = lfmf_pkg::store_addr(ws_reg, put_pos);
                                if (req.data_byte == lfmf_pkg::CH_NL)
                                begin
                                    // comma now, newline next cycle
                                    mem_wdata      = lfmf_pkg::CH_COMMA;
                                    pend_addr_next = lfmf_pkg::addr_t'(mem_waddr + 1'b1);
                                    pend_left_next = 2'd1;
                                    ws_next        = lfmf_pkg::slot_inc(ws_reg);
                                    wpos_next      = '0;
                                    state_next     = lfmf_pkg::S_PUT;
                                    oc_next        = lfmf_pkg::count_out(
                                        lfmf_pkg::slot_cnt_t'(count_cur + 1'b1));
                                end
                                else
                                begin
                                    mem_wdata = req.data_byte;
                                    if (put_pos == lfmf_pkg::POS_CLOSE)
                                    begin
                                        // slot full: append comma and newline
                                        pend_addr_next = lfmf_pkg::addr_t'(mem_waddr + 1'b1);
                                        pend_left_next = 2'd2;
                                        ws_next        = lfmf_pkg::slot_inc(ws_reg);
                                        wpos_next      = '0;
                                        state_next     = lfmf_pkg::S_PUT;
                                        oc_next        = lfmf_pkg::count_out(
                                            lfmf_pkg::slot_cnt_t'(count_cur + 1'b1));
                                    end
                                    else
                                    begin
                                        wpos_next = lfmf_pkg::pos_t'(put_pos + 1'b1);
                                    end
                                end
                            end
                        end
                        lfmf_pkg::REQ_GET:
                        begin
                            if (count_cur == '0)
                            begin
                                os_next = lfmf_pkg::ST_EMPTY;
                                oc_next = 4'd0;
                            end
                            else
                            begin
                                ov_next    = 1'b0;
                                j_next     = '0;
                                state_next = lfmf_pkg::S_GET;
                            end
                        end
                        lfmf_pkg::REQ_FLUSH:
                        begin
                            ws_next   = '0;
                            rs_next   = '0;
                            wpos_next = '0;
                            oc_next   = 4'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            lfmf_pkg::S_PUT:
            begin
                mem_we         = 1'b1;
                pend_addr_next = lfmf_pkg::addr_t'(pend_addr_reg + 1'b1);
                pend_left_next = pend_left_reg - 2'd1;
                if (pend_left_reg == 2'd1)
                    state_next = lfmf_pkg::S_IDLE;
            end
            lfmf_pkg::S_GET:
            begin
                // rd_data_reg holds the byte at j_reg
                if (out_free)
                begin
                    ov_next = 1'b1;
                    ob_next = rd_data_reg;
                    ol_next = get_fin;
                    os_next = lfmf_pkg::ST_OK;
                    if (get_fin)
                    begin
                        rs_next    = lfmf_pkg::slot_inc(rs_reg);
                        oc_next    = lfmf_pkg::count_out(
                            lfmf_pkg::slot_cnt_t'(count_cur - 1'b1));
                        state_next = lfmf_pkg::S_IDLE;
                    end
                    else
                    begin
                        oc_next = lfmf_pkg::count_out(count_cur);
                        j_next  = lfmf_pkg::pos_t'(j_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = lfmf_pkg::S_IDLE;
            end
        endcase
    end

    // Read address follows the next index, so the registered data lines up with j_reg.
    assign rd_addr = lfmf_pkg::store_addr(rs_reg, j_next);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            message_store[mem_waddr] <= mem_wdata;
        rd_data_reg <= message_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfmf_pkg::S_IDLE;
            ws_reg        <= '0;
            rs_reg        <= '0;
            wpos_reg      <= '0;
            pend_left_reg <= 2'd0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            wpos_reg      <= wpos_next;
            pend_left_reg <= pend_left_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        pend_addr_reg <= pend_addr_next;
        ob_reg        <= ob_next;
        ol_reg        <= ol_next;
        os_reg        <= os_next;
        oc_reg        <= oc_next;
    end

`include "line_framed_message_fifo_assert.svh"

    `LFMF_ASSERT_NOW(a_count_bound, 1'b1, count_cur <= lfmf_pkg::SLOTS_CNT, "count over slots")
    `LFMF_ASSERT_NOW(a_no_write_in_get, state_reg == lfmf_pkg::S_GET, !mem_we, "write in get")
    `LFMF_ASSERT_NOW(a_put_pend, state_reg == lfmf_pkg::S_PUT, pend_left_reg != '0, "no write left")
    `LFMF_ASSERT_NEXT(a_get_free, get_take && get_fin, rs_reg != $past(rs_reg), "slot not freed")

endmodule

// ----- sim/testbench.sv -----
module testbench;

    localparam logic [1:0] REQ_SPARE = 2'd3;   // unused request code
    localparam int         RING_MOD  = 2 * lfmf_pkg::SLOTS;
    localparam int         TAIL_WAIT = 20;
    localparam int         MAX_CYCLES = 800000;
    localparam int         RANDOM_REQS = 285;
    localparam int         DRAIN_AT  = 140;
    localparam int         LONG_HOLD = 400;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              last;
        lfmf_pkg::status_t status;
        logic [3:0]        count;
    } fifo_res_t;

    typedef struct {
        logic [1:0]        code;
        logic [7:0]        data;
        int                rep;
        bit                typed;
        lfmf_pkg::status_t status;
        logic [3:0]        count;
    } plan_row_t;

    logic clk;
    logic rst_n;

    lfmf_req_if req_if ();
    lfmf_res_if res_if ();

    line_framed_message_fifo DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if)
    );

    // shadow of the message ring
    logic [7:0] ring_mem [lfmf_pkg::SLOTS*lfmf_pkg::MESSAGE_BYTES];
    int         wr_slot;
    int         rd_slot;
    int         wr_pos;

    fifo_res_t  due_results[$];
    plan_row_t  plan_rows[$];
    int         err_count;
    bit         tx_calm;
    int         cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < MAX_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        flag($sformatf("timeout after %0d cycles, %0d results outstanding",
                       cycles, due_results.size()));
        $display("Mismatches found");
        $finish;
    end

    task automatic flag(input string what);
        err_count++;
        if (err_count <= 100)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic int ring_held();
        int d;
        d = wr_slot - rd_slot;
        if (d < 0)
            d += RING_MOD;
        return d;
    endfunction

    function automatic fifo_res_t mk_res(input logic [7:0] b, input logic l,
                                         input lfmf_pkg::status_t s, input int c);
        fifo_res_t r;
        r.out_byte = b;
        r.last     = l;
        r.status   = s;
        r.count    = 4'(c);
        return r;
    endfunction

    function automatic void ring_close();
        wr_slot = (wr_slot + 1) % RING_MOD;
        wr_pos  = 0;
    endfunction

    // Expected results of one request; advances the shadow ring.
    function automatic void ring_apply(input logic [1:0] code, input logic [7:0] d,
                                       output fifo_res_t got[$]);
        int         held;
        int         base;
        int         j;
        logic [7:0] b;
        got  = {};
        held = ring_held();
        case (code)
            lfmf_pkg::REQ_PUT:
            begin
                if (held >= lfmf_pkg::SLOTS)
                begin
                    got.push_back(mk_res(8'h00, 1'b1, lfmf_pkg::ST_FULL, held));
                end
                else
                begin
                    base = (wr_slot % lfmf_pkg::SLOTS) * lfmf_pkg::MESSAGE_BYTES;
                    if (d == lfmf_pkg::CH_NL)
                    begin
                        ring_mem[base + wr_pos]     = lfmf_pkg::CH_COMMA;
                        ring_mem[base + wr_pos + 1] = lfmf_pkg::CH_NL;
                        ring_close();
                    end
                    else
                    begin
                        ring_mem[base + wr_pos] = d;
                        if (wr_pos == lfmf_pkg::MESSAGE_BYTES - 3)
                        begin
                            ring_mem[base + lfmf_pkg::MESSAGE_BYTES - 2] = lfmf_pkg::CH_COMMA;
                            ring_mem[base + lfmf_pkg::MESSAGE_BYTES - 1] = lfmf_pkg::CH_NL;
                            ring_close();
                        end
                        else
                        begin
                            wr_pos++;
                        end
                    end
                    got.push_back(mk_res(8'h00, 1'b1, lfmf_pkg::ST_OK, ring_held()));
                end
            end
            lfmf_pkg::REQ_GET:
            begin
                if (held == 0)
                begin
                    got.push_back(mk_res(8'h00, 1'b1, lfmf_pkg::ST_EMPTY, 0));
                end
                else
                begin
                    base = (rd_slot % lfmf_pkg::SLOTS) * lfmf_pkg::MESSAGE_BYTES;
                    for (j = 0; j < lfmf_pkg::MESSAGE_BYTES; j++)
                    begin
                        b = ring_mem[base + j];
                        if (b == lfmf_pkg::CH_NL || j == lfmf_pkg::MESSAGE_BYTES - 1)
                        begin
                            rd_slot = (rd_slot + 1) % RING_MOD;
                            got.push_back(mk_res(b, 1'b1, lfmf_pkg::ST_OK, ring_held()));
                            break;
                        end
                        got.push_back(mk_res(b, 1'b0, lfmf_pkg::ST_OK, held));
                    end
                end
            end
            lfmf_pkg::REQ_FLUSH:
            begin
                wr_slot = 0;
                rd_slot = 0;
                wr_pos  = 0;
                got.push_back(mk_res(8'h00, 1'b1, lfmf_pkg::ST_OK, 0));
            end
            default:
            begin
                got.push_back(mk_res(8'h00, 1'b1, lfmf_pkg::ST_OK, held));
            end
        endcase
    endfunction

    task automatic plan(input logic [1:0] code, input logic [7:0] data, input int rep,
                        input bit typed, input lfmf_pkg::status_t st, input int cnt);
        plan_row_t r;
        r.code   = code;
        r.data   = data;
        r.rep    = rep;
        r.typed  = typed;
        r.status = st;
        r.count  = 4'(cnt);
        plan_rows.push_back(r);
    endtask

    // Offer one request; on acceptance queue what it should produce.
    task automatic issue(input logic [1:0] code, input logic [7:0] d, input bit typed,
                         input lfmf_pkg::status_t st, input logic [3:0] cnt);
        int        gap;
        fifo_res_t got[$];
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 24) == 0)
            tx_calm = !tx_calm;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= code;
        req_if.data_byte <= d;
        do @(posedge clk); while (!req_if.ready);
        ring_apply(code, d, got);
        if (typed)
            due_results.push_back(mk_res(8'h00, 1'b1, st, int'(cnt)));
        else
            foreach (got[i])
                due_results.push_back(got[i]);
    endtask

    // result side: random stalls, one long hold-off to back up the block
    initial
    begin
        int        gap;
        int        taken;
        bit        rx_calm;
        bit        held_done;
        fifo_res_t want;
        taken     = 0;
        rx_calm   = 1'b0;
        held_done = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = rx_calm ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 29) == 0)
                rx_calm = !rx_calm;
            if (!held_done && taken == 150)
            begin
                gap       = LONG_HOLD;
                held_done = 1'b1;
            end
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            taken++;
            if (due_results.size() == 0)
            begin
                flag($sformatf("unexpected result byte=%02h last=%0b status=%0d count=%0d",
                               res_if.out_byte, res_if.last, res_if.status,
                               res_if.message_count));
            end
            else
            begin
                want = due_results.pop_front();
                if (res_if.out_byte !== want.out_byte)
                    flag($sformatf("result %0d out_byte %02h, want %02h",
                                   taken, res_if.out_byte, want.out_byte));
                if (res_if.last !== want.last)
                    flag($sformatf("result %0d last %0b, want %0b",
                                   taken, res_if.last, want.last));
                if (res_if.status !== want.status)
                    flag($sformatf("result %0d status %0d, want %0d",
                                   taken, res_if.status, want.status));
                if (res_if.message_count !== want.count)
                    flag($sformatf("result %0d message_count %0d, want %0d",
                                   taken, res_if.message_count, want.count));
            end
        end
    end

    initial
    begin
        int         sent;
        int         pick;
        int         get_w;
        int         len;
        bit         drained;
        logic [7:0] b;
        err_count = 0;
        tx_calm   = 1'b0;
        wr_slot   = 0;
        rd_slot   = 0;
        wr_pos    = 0;
        foreach (ring_mem[i])
            ring_mem[i] = 8'h00;
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.req_type  <= lfmf_pkg::REQ_PUT;
        req_if.data_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  1, lfmf_pkg::ST_EMPTY, 0);
        plan(REQ_SPARE,           8'hFF,             1,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_FLUSH, 8'h00,             1,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   8'h00,             1,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   8'hFF,             1,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_COMMA, 1, 1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_NL,   1,  1, lfmf_pkg::ST_OK,    1);
        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  0, lfmf_pkg::ST_OK,    0);
        // slot runs out of room: comma and newline forced after byte 62
        plan(lfmf_pkg::REQ_PUT,   8'h41,             61, 1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   8'h42,             1,  1, lfmf_pkg::ST_OK,    1);
        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  0, lfmf_pkg::ST_OK,    0);
        // flush drops a half-written message
        plan(lfmf_pkg::REQ_PUT,   8'h33,             5,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_FLUSH, 8'h00,             1,  1, lfmf_pkg::ST_OK,    0);
        // fill every slot, then puts are refused
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_NL,   8,  0, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   8'h55,             1,  1, lfmf_pkg::ST_FULL,  8);
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_NL,   1,  1, lfmf_pkg::ST_FULL,  8);
        plan(REQ_SPARE,           8'h00,             1,  1, lfmf_pkg::ST_OK,    8);
        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  0, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   8'h80,             1,  0, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_NL,   1,  1, lfmf_pkg::ST_OK,    8);
        plan(lfmf_pkg::REQ_FLUSH, 8'h00,             1,  1, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  1, lfmf_pkg::ST_EMPTY, 0);
        plan(lfmf_pkg::REQ_PUT,   8'h7F,             1,  0, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_PUT,   lfmf_pkg::CH_NL,   1,  0, lfmf_pkg::ST_OK,    0);
        plan(lfmf_pkg::REQ_GET,   8'h00,             1,  0, lfmf_pkg::ST_OK,    0);

        foreach (plan_rows[r])
            for (int k = 0; k < plan_rows[r].rep; k++)
                issue(plan_rows[r].code, plan_rows[r].data, plan_rows[r].typed,
                      plan_rows[r].status, plan_rows[r].count);

        sent    = 0;
        get_w   = 25;
        drained = 1'b0;
        while (sent < RANDOM_REQS)
        begin
            if (!drained && sent >= DRAIN_AT)
            begin
                // let the block drain completely once
                req_if.valid <= 1'b0;
                do @(posedge clk); while (due_results.size() != 0);
                drained = 1'b1;
            end
            if ($urandom_range(0, 14) == 0)
                get_w = $urandom_range(5, 45);
            pick = $urandom_range(0, 99);
            if (pick < get_w)
            begin
                issue(lfmf_pkg::REQ_GET, 8'($urandom_range(0, 255)), 1'b0,
                      lfmf_pkg::ST_OK, 4'd0);
                sent++;
            end
            else if (pick < get_w + 4)
            begin
                issue(lfmf_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)), 1'b0,
                      lfmf_pkg::ST_OK, 4'd0);
                sent++;
            end
            else if (pick < get_w + 8)
            begin
                issue(REQ_SPARE, 8'($urandom_range(0, 255)), 1'b0, lfmf_pkg::ST_OK, 4'd0);
                sent++;
            end
            else if (pick < get_w + 14)
            begin
                // noise: any code, any byte
                issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'b0, lfmf_pkg::ST_OK, 4'd0);
                sent++;
            end
            else
            begin
                // well-formed message; now and then long enough to hit the forced close
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                                  : $urandom_range(0, 8);
                for (int k = 0; k < len; k++)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == lfmf_pkg::CH_NL)
                        b = b ^ 8'h01;
                    issue(lfmf_pkg::REQ_PUT, b, 1'b0, lfmf_pkg::ST_OK, 4'd0);
                end
                issue(lfmf_pkg::REQ_PUT, lfmf_pkg::CH_NL, 1'b0, lfmf_pkg::ST_OK, 4'd0);
                sent += len + 1;
            end
        end
        req_if.valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
